// ===== sv/fstc_pkg.sv =====
// ----------------------------------------------------------------------------
// fstc_pkg
// Shared constants and types for the flow-state two-level cache controller.
// ----------------------------------------------------------------------------
package fstc_pkg;

	localparam int FLOW_W    = 24;
	localparam int WAYS      = 16;
	localparam int WAY_W     = $clog2(WAYS);
	localparam int SLOTS_DEF = 512;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	localparam logic [31:0] SENTINEL = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		SRC_NONE    = 2'd0,
		SRC_SWAP    = 2'd1,
		SRC_VICTIM  = 2'd2,
		SRC_BACKING = 2'd3
	} fetch_src_t;

	// Classified request handed from the lookup front to the victim-level back.
	typedef struct packed {
		logic [FLOW_W-1:0] fid;
		logic              hit;
		logic [WAY_W-1:0]  way;
		logic              ev_valid;
		logic [FLOW_W-1:0] ev_id;
	} cmd_t;

endpackage

// ===== sv/flow_state_two_level_cache_ctrl_core.sv =====
// ----------------------------------------------------------------------------
// flow_state_two_level_cache_ctrl_core
// Tag and placement controller for a 16-way LRU first level backed by a
// direct-mapped victim level.
//
//   Channel   Direction  Handshake              Payload
//   request   in         start high, busy low   flow_id
//   result    out        done strobe, 1 cycle   hit .. fetch_slot
//
// A request is classified in the cycle after acceptance and queued. With the
// back end idle, a hit is answered from the idle state, a miss with no real
// eviction goes through the fetch state, and any other miss goes through the
// evict state, where a swap ends it, and then the fetch state. The back end
// takes one queued request at a time through the victim-level memory port.
// After reset, busy stays high while the victim memory is cleared. busy also
// rises when the request queue is full. Results cannot be stalled; flow id 0
// is accepted and dropped without a result.
// ----------------------------------------------------------------------------
module flow_state_two_level_cache_ctrl_core
	import fstc_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [FLOW_W-1:0]          flow_id,
	output logic                       done,
	output logic                       hit,
	output logic [WAY_W-1:0]           way_index,
	output logic                       evict_valid,
	output logic [FLOW_W-1:0]          evict_flow_id,
	output logic [$clog2(SLOTS)-1:0]   evict_slot,
	output logic                       spill_valid,
	output logic [FLOW_W-1:0]          spill_flow_id,
	output logic [1:0]                 fetch_source,
	output logic [$clog2(SLOTS)-1:0]   fetch_slot
);

	logic              accept;
	logic              pending;
	logic              push;
	cmd_t              cmd;
	cmd_t              q_head;
	logic              q_empty;
	logic              q_pop;
	logic [QCNT_W-1:0] q_count;
	logic              clearing;

	// Reserve a queue entry for the request still in the lookup stage.
	assign busy   = clearing || ((q_count + QCNT_W'(pending)) >= QCNT_W'(QDEPTH));
	assign accept = start && !busy;

	fstc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.flow_id (flow_id),
		.pending (pending),
		.push    (push),
		.cmd     (cmd)
	);

	fstc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (cmd),
		.pop    (q_pop),
		.dout   (q_head),
		.empty  (q_empty),
		.count  (q_count)
	);

	fstc_back #(
		.SLOTS (SLOTS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.clearing      (clearing),
		.done          (done),
		.hit           (hit),
		.way_index     (way_index),
		.evict_valid   (evict_valid),
		.evict_flow_id (evict_flow_id),
		.evict_slot    (evict_slot),
		.spill_valid   (spill_valid),
		.spill_flow_id (spill_flow_id),
		.fetch_source  (fetch_source),
		.fetch_slot    (fetch_slot)
	);

endmodule

// ===== sv/fstc_front.sv =====
// ----------------------------------------------------------------------------
// fstc_front
// Associative first level: tag lookup, LRU victim choice and way update.
// ----------------------------------------------------------------------------
module fstc_front
	import fstc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [FLOW_W-1:0] flow_id,
	output logic              pending,
	output logic              push,
	output cmd_t              cmd
);

	logic              valid_s1;
	logic [FLOW_W-1:0] fid_s1;
	logic [FLOW_W-1:0] tags_q [WAYS];
	logic              valid_q [WAYS];
	logic [WAY_W-1:0]  age_q [WAYS];

	logic              hit;
	logic              ev_valid;
	logic [WAY_W-1:0]  hit_way;
	logic [WAY_W-1:0]  vic_way;
	logic [WAY_W-1:0]  way_sel;

	function automatic logic [FLOW_W-1:0] sentinel_tag(input int unsigned idx);
		logic [31:0] t;
		t = SENTINEL - 32'(idx);
		return t[FLOW_W-1:0];
	endfunction

	// Ages always form a permutation, so the oldest way is the one at the top age.
	always_comb begin
		hit     = 1'b0;
		hit_way = '0;
		vic_way = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			if (valid_q[i] && (tags_q[i] == fid_s1)) begin
				hit     = 1'b1;
				hit_way = WAY_W'(i);
			end
			if (age_q[i] == WAY_W'(WAYS - 1)) begin
				vic_way = WAY_W'(i);
			end
		end
		way_sel      = hit ? hit_way : vic_way;
		ev_valid     = !hit && valid_q[vic_way];
		cmd.fid      = fid_s1;
		cmd.hit      = hit;
		cmd.way      = way_sel;
		cmd.ev_valid = ev_valid;
		cmd.ev_id    = ev_valid ? tags_q[vic_way] : '0;
	end

	assign pending = valid_s1;
	assign push    = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			for (int i = 0; i < WAYS; i++) begin
				tags_q[i]  <= sentinel_tag(i);
				valid_q[i] <= 1'b0;
				age_q[i]   <= WAY_W'(i);
			end
		end else begin
			valid_s1 <= accept && (flow_id != '0);
			if (valid_s1) begin
				tags_q[way_sel]  <= fid_s1;
				valid_q[way_sel] <= 1'b1;
				for (int i = 0; i < WAYS; i++) begin
					if (WAY_W'(i) == way_sel) begin
						age_q[i] <= '0;
					end else if (age_q[i] < age_q[way_sel]) begin
						age_q[i] <= age_q[i] + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fid_s1 <= flow_id;
		end
	end

endmodule

// ===== sv/fstc_queue.sv =====
// ----------------------------------------------------------------------------
// fstc_queue
// Small FIFO of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module fstc_queue
	import fstc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cmd_t              din,
	input  logic              pop,
	output cmd_t              dout,
	output logic              empty,
	output logic [QCNT_W-1:0] count
);

	cmd_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign dout  = entry_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

endmodule

// ===== sv/fstc_back.sv =====
// ----------------------------------------------------------------------------
// fstc_back
// Victim level: slot-owner memory, eviction, spill and fetch classification.
// ----------------------------------------------------------------------------
module fstc_back
	import fstc_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_empty,
	input  cmd_t                       q_head,
	output logic                       q_pop,
	output logic                       clearing,
	output logic                       done,
	output logic                       hit,
	output logic [WAY_W-1:0]           way_index,
	output logic                       evict_valid,
	output logic [FLOW_W-1:0]          evict_flow_id,
	output logic [$clog2(SLOTS)-1:0]   evict_slot,
	output logic                       spill_valid,
	output logic [FLOW_W-1:0]          spill_flow_id,
	output logic [1:0]                 fetch_source,
	output logic [$clog2(SLOTS)-1:0]   fetch_slot
);

	localparam int SLOT_W = $clog2(SLOTS);

	typedef enum logic [3:0] {
		B_CLEAR = 4'b0001,
		B_IDLE  = 4'b0010,
		B_EVICT = 4'b0100,
		B_FETCH = 4'b1000
	} bstate_t;

	bstate_t           state_q;
	bstate_t           state_d;
	logic [SLOT_W-1:0] clr_idx_q;
	cmd_t              cmd_q;
	logic              sp_valid_q;
	logic [FLOW_W-1:0] sp_id_q;

	logic [FLOW_W-1:0] mem [SLOTS];
	logic [FLOW_W-1:0] rd_q;
	logic [SLOT_W-1:0] raddr;
	logic              we;
	logic [SLOT_W-1:0] waddr;
	logic [FLOW_W-1:0] wdata;

	logic              emit;
	logic              r_hit;
	logic [WAY_W-1:0]  r_way;
	logic              r_ev_valid;
	logic [FLOW_W-1:0] r_ev_id;
	logic              r_sp_valid;
	logic [FLOW_W-1:0] r_sp_id;
	fetch_src_t        r_src;
	logic [SLOT_W-1:0] r_fslot;
	logic              sp_load;
	logic              sp_valid_d;

	logic [SLOT_W-1:0] es;
	logic [SLOT_W-1:0] in_slot;

	assign es       = cmd_q.ev_id[SLOT_W-1:0];
	assign in_slot  = cmd_q.fid[SLOT_W-1:0];
	assign clearing = (state_q == B_CLEAR);

	always_comb begin
		state_d    = state_q;
		q_pop      = 1'b0;
		raddr      = in_slot;
		we         = 1'b0;
		waddr      = clr_idx_q;
		wdata      = '0;
		emit       = 1'b0;
		r_hit      = 1'b0;
		r_way      = cmd_q.way;
		r_ev_valid = cmd_q.ev_valid;
		r_ev_id    = cmd_q.ev_id;
		r_sp_valid = sp_valid_q;
		r_sp_id    = sp_id_q;
		r_src      = SRC_NONE;
		r_fslot    = in_slot;
		sp_load    = 1'b0;
		sp_valid_d = 1'b0;
		unique case (state_q)
			B_CLEAR: begin
				we = 1'b1;
				if (clr_idx_q == SLOT_W'(SLOTS - 1)) begin
					state_d = B_IDLE;
				end
			end
			B_IDLE: begin
				raddr = q_head.ev_valid ? q_head.ev_id[SLOT_W-1:0] : q_head.fid[SLOT_W-1:0];
				if (!q_empty) begin
					q_pop = 1'b1;
					if (q_head.hit) begin
						emit       = 1'b1;
						r_hit      = 1'b1;
						r_way      = q_head.way;
						r_ev_valid = 1'b0;
						r_ev_id    = '0;
						r_sp_valid = 1'b0;
						r_sp_id    = '0;
						r_fslot    = q_head.fid[SLOT_W-1:0];
					end else if (q_head.ev_valid) begin
						state_d = B_EVICT;
					end else begin
						// Nothing to evict: no spill for this transaction.
						sp_load = 1'b1;
						state_d = B_FETCH;
					end
				end
			end
			B_EVICT: begin
				we    = 1'b1;
				waddr = es;
				wdata = cmd_q.ev_id;
				if (rd_q == cmd_q.fid) begin
					emit       = 1'b1;
					r_sp_valid = 1'b0;
					r_sp_id    = '0;
					r_src      = SRC_SWAP;
					state_d    = B_IDLE;
				end else begin
					// A read of the slot just written returns the old occupant,
					// which is not the requested flow here, so the fetch check holds.
					sp_load    = 1'b1;
					sp_valid_d = (rd_q != '0);
					state_d    = B_FETCH;
				end
			end
			B_FETCH: begin
				emit    = 1'b1;
				state_d = B_IDLE;
				if (rd_q == cmd_q.fid) begin
					we    = 1'b1;
					waddr = in_slot;
					r_src = SRC_VICTIM;
				end else begin
					r_src = SRC_BACKING;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_CLEAR;
			clr_idx_q <= '0;
			done      <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= emit;
			if (state_q == B_CLEAR) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_head;
		end
		if (sp_load) begin
			sp_valid_q <= sp_valid_d;
			sp_id_q    <= sp_valid_d ? rd_q : '0;
		end
		if (emit) begin
			hit           <= r_hit;
			way_index     <= r_way;
			evict_valid   <= r_ev_valid;
			evict_flow_id <= r_ev_id;
			evict_slot    <= r_ev_valid ? r_ev_id[SLOT_W-1:0] : '0;
			spill_valid   <= r_sp_valid;
			spill_flow_id <= r_sp_id;
			fetch_source  <= r_src;
			fetch_slot    <= r_fslot;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

endmodule

// ===== sv/fstc_checker.sv =====
// ----------------------------------------------------------------------------
// fstc_checker
// Port-level checks on result consistency and reset behavior.
// ----------------------------------------------------------------------------
module fstc_checker
	import fstc_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              busy,
	input logic              done,
	input logic              hit,
	input logic              evict_valid,
	input logic [FLOW_W-1:0] evict_flow_id,
	input logic              spill_valid,
	input logic [FLOW_W-1:0] spill_flow_id,
	input logic [1:0]        fetch_source
);

	// The victim memory clear keeps the block busy right after reset.
	a_busy_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> busy)
		else $error("block not busy after reset release");

	a_hit_no_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> (fetch_source == SRC_NONE) && !evict_valid && !spill_valid)
		else $error("hit transaction reports a fetch or an eviction");

	a_miss_fetches: assert property (@(posedge clk) disable iff (!arst_n)
		done && !hit |-> fetch_source != SRC_NONE)
		else $error("miss transaction without a fetch source");

	a_spill_needs_evict: assert property (@(posedge clk) disable iff (!arst_n)
		done && (spill_valid || (fetch_source == SRC_SWAP)) |-> evict_valid
			&& !(spill_valid && (fetch_source == SRC_SWAP)))
		else $error("spill or swap without a matching eviction");

	a_zero_ids: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (evict_valid || (evict_flow_id == '0))
			&& (spill_valid || (spill_flow_id == '0)))
		else $error("flow id reported without its valid flag");

endmodule

bind flow_state_two_level_cache_ctrl_core fstc_checker u_fstc_checker (.*);

// ===== test/tb_flow_state_two_level_cache_ctrl_core.sv =====
// ----------------------------------------------------------------------------
// tb_flow_state_two_level_cache_ctrl_core
// Self-checking bench for the two-level flow-state cache controller. A driver
// sends flow ids in random bursts. It starts with a directed sequence that
// walks through invalid ways, sentinel ids, victim reads, swaps and spills,
// then sends random traffic drawn mostly from small pools of flows that
// collide in the victim level. A model of the LRU ways and victim slots
// predicts every result. A monitor compares each result field by field.
// ----------------------------------------------------------------------------
module tb_flow_state_two_level_cache_ctrl_core;
	import fstc_pkg::*;

	localparam int SLOT_W       = $clog2(SLOTS_DEF);
	localparam int RANDOM_ITEMS = 1100;
	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 16;

	typedef struct packed {
		logic              hit;
		logic [WAY_W-1:0]  way;
		logic              ev_valid;
		logic [FLOW_W-1:0] ev_id;
		logic [SLOT_W-1:0] ev_slot;
		logic              sp_valid;
		logic [FLOW_W-1:0] sp_id;
		fetch_src_t        src;
		logic [SLOT_W-1:0] fetch_slot;
	} lookup_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [FLOW_W-1:0] flow_id = '0;
	logic busy;
	logic done;
	logic hit;
	logic [WAY_W-1:0] way_index;
	logic evict_valid;
	logic [FLOW_W-1:0] evict_flow_id;
	logic [SLOT_W-1:0] evict_slot;
	logic spill_valid;
	logic [FLOW_W-1:0] spill_flow_id;
	logic [1:0] fetch_source;
	logic [SLOT_W-1:0] fetch_slot;

	// Model of the cache state.
	logic [FLOW_W-1:0] way_tag [WAYS];
	logic              way_vld [WAYS];
	logic [WAY_W-1:0]  way_age [WAYS];
	logic [FLOW_W-1:0] slot_occ [SLOTS_DEF];

	logic [FLOW_W-1:0] pending_ids [$];
	lookup_res_t       expected_results [$];
	int                fail_count = 0;
	int                burst_left = 0;
	int                gap_left = 0;

	flow_state_two_level_cache_ctrl_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.flow_id       (flow_id),
		.done          (done),
		.hit           (hit),
		.way_index     (way_index),
		.evict_valid   (evict_valid),
		.evict_flow_id (evict_flow_id),
		.evict_slot    (evict_slot),
		.spill_valid   (spill_valid),
		.spill_flow_id (spill_flow_id),
		.fetch_source  (fetch_source),
		.fetch_slot    (fetch_slot)
	);

	always #6 clk = ~clk;

	function automatic void clear_cache_model();
		for (int i = 0; i < WAYS; i++) begin
			way_tag[i] = SENTINEL[FLOW_W-1:0] - FLOW_W'(i);
			way_vld[i] = 1'b0;
			way_age[i] = WAY_W'(i);
		end
		for (int i = 0; i < SLOTS_DEF; i++)
			slot_occ[i] = '0;
	endfunction

	// Returns 0 for flow 0, which the block drops without a result.
	function automatic bit predict_lookup(input logic [FLOW_W-1:0] fid,
			output lookup_res_t r);
		int w;
		bit found;
		bit swapped;
		logic [FLOW_W-1:0] ev;
		logic [FLOW_W-1:0] old;
		logic [SLOT_W-1:0] es;
		logic [SLOT_W-1:0] fslot;
		logic [WAY_W-1:0] a;

		r = '0;
		fslot = fid[SLOT_W-1:0];
		r.fetch_slot = fslot;
		if (fid == '0)
			return 1'b0;
		w = 0;
		found = 1'b0;
		swapped = 1'b0;
		for (int i = 0; i < WAYS; i++) begin
			if (!found && way_vld[i] && way_tag[i] == fid) begin
				w = i;
				found = 1'b1;
			end
		end
		if (found) begin
			r.hit = 1'b1;
			r.src = SRC_NONE;
		end else begin
			// Oldest way is replaced; strict compare keeps the lowest index on a tie.
			for (int i = 1; i < WAYS; i++)
				if (way_age[i] > way_age[w])
					w = i;
			if (way_vld[w]) begin
				ev = way_tag[w];
				es = ev[SLOT_W-1:0];
				old = slot_occ[es];
				slot_occ[es] = ev;
				r.ev_valid = 1'b1;
				r.ev_id = ev;
				r.ev_slot = es;
				if (old != '0) begin
					if (old == fid) begin
						swapped = 1'b1;
						r.src = SRC_SWAP;
					end else begin
						r.sp_valid = 1'b1;
						r.sp_id = old;
					end
				end
			end
			if (!swapped) begin
				if (slot_occ[fslot] == fid) begin
					slot_occ[fslot] = '0;
					r.src = SRC_VICTIM;
				end else begin
					r.src = SRC_BACKING;
				end
			end
			way_tag[w] = fid;
			way_vld[w] = 1'b1;
		end
		a = way_age[w];
		for (int i = 0; i < WAYS; i++)
			if (way_age[i] < a)
				way_age[i]++;
		way_age[w] = '0;
		r.way = WAY_W'(w);
		return 1'b1;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	// Driver: predicts each accepted transaction, then presents the next id.
	always @(posedge clk or negedge arst_n) begin : driver
		lookup_res_t res;
		if (!arst_n) begin
			start <= 1'b0;
			flow_id <= '0;
		end else begin
			if (start && !busy) begin
				if (predict_lookup(flow_id, res))
					expected_results.push_back(res);
			end
			if (start && busy) begin
				// Hold the transaction until the block takes it.
			end else if (gap_left != 0) begin
				start <= 1'b0;
				gap_left--;
			end else if (pending_ids.size() != 0) begin
				start <= 1'b1;
				flow_id <= pending_ids.pop_front();
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 40);
					case ($urandom_range(0, 7))
						0, 1, 2: gap_left = 0;
						3:       gap_left = $urandom_range(10, 25);
						default: gap_left = $urandom_range(1, 6);
					endcase
				end else begin
					burst_left--;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : monitor
		lookup_res_t want;
		if (arst_n && done === 1'b1) begin
			if (expected_results.size() == 0) begin
				$error("result with no request outstanding");
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("hit", 32'(want.hit), 32'(hit));
				check_field("way_index", 32'(want.way), 32'(way_index));
				check_field("evict_valid", 32'(want.ev_valid), 32'(evict_valid));
				check_field("evict_flow_id", 32'(want.ev_id), 32'(evict_flow_id));
				check_field("evict_slot", 32'(want.ev_slot), 32'(evict_slot));
				check_field("spill_valid", 32'(want.sp_valid), 32'(spill_valid));
				check_field("spill_flow_id", 32'(want.sp_id), 32'(spill_flow_id));
				check_field("fetch_source", 32'(want.src), 32'(fetch_source));
				check_field("fetch_slot", 32'(want.fetch_slot), 32'(fetch_slot));
			end
		end
	end

	initial begin : sequencer
		logic [SLOT_W-1:0] pool_slot [12];
		logic [FLOW_W-SLOT_W-1:0] pool_upper [6];
		logic [FLOW_W-1:0] id;
		int n_slots;
		int sent;
		int cycles;
		int pick;

		clear_cache_model();

		// Directed: an all-ones id equal to an invalid way's tag must miss, flow 0
		// is dropped, then the ways fill with flows sharing victim slot 5 so the
		// following misses give a plain eviction, a victim read, a swap and spills.
		pending_ids.push_back(24'hFF_FFFF);
		pending_ids.push_back(24'h00_0000);
		pending_ids.push_back(24'h00_0001);
		pending_ids.push_back(24'hFF_FFFF);
		for (int k = 1; k <= 14; k++)
			pending_ids.push_back(FLOW_W'((k << SLOT_W) | 5));
		pending_ids.push_back(FLOW_W'((15 << SLOT_W) | 5));
		pending_ids.push_back(24'h00_0001);
		pending_ids.push_back(FLOW_W'((16 << SLOT_W) | 5));
		pending_ids.push_back(FLOW_W'((1 << SLOT_W) | 5));
		pending_ids.push_back(FLOW_W'((17 << SLOT_W) | 5));
		pending_ids.push_back(24'hFF_FFEF);
		pending_ids.push_back(24'hFF_FFF0);

		// Random: three segments, each with its own pool of colliding flows.
		sent = 0;
		for (int seg = 0; seg < 3; seg++) begin
			n_slots = (seg == 0) ? 3 : (seg == 1) ? 6 : 12;
			foreach (pool_slot[i])
				pool_slot[i] = SLOT_W'($urandom_range(0, SLOTS_DEF - 1));
			foreach (pool_upper[i])
				pool_upper[i] = (FLOW_W-SLOT_W)'($urandom_range(1, (1 << (FLOW_W-SLOT_W)) - 1));
			while (sent < (seg + 1) * RANDOM_ITEMS / 3) begin
				pick = $urandom_range(0, 99);
				if (pick < 65) begin
					id = {pool_upper[$urandom_range(0, 5)],
						pool_slot[$urandom_range(0, n_slots - 1)]};
				end else if (pick < 80) begin
					id = pending_ids[pending_ids.size() - 1 - $urandom_range(0, 15)];
				end else if (pick < 95) begin
					id = FLOW_W'($urandom_range(1, (1 << FLOW_W) - 1));
				end else if (pick < 98) begin
					id = '0;
				end else begin
					id = SENTINEL[FLOW_W-1:0] - FLOW_W'($urandom_range(0, WAYS - 1));
				end
				pending_ids.push_back(id);
				if (id != '0)
					sent++;
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		cycles = 0;
		do begin
			@(negedge clk);
			cycles++;
		end while (cycles < LIMIT_CYCLES && (pending_ids.size() != 0 || start ||
			expected_results.size() != 0));

		if (cycles >= LIMIT_CYCLES) begin
			$display("FAIL flow_state_two_level_cache_ctrl_core");
		end else begin
			repeat (DRAIN_CYCLES) @(negedge clk);
			if (fail_count == 0 && expected_results.size() == 0)
				$display("PASS flow_state_two_level_cache_ctrl_core");
			else
				$display("FAIL flow_state_two_level_cache_ctrl_core");
		end
		$finish;
	end

endmodule
